// ----- sv/assert_macros.svh -----
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RFA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RFA_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RFA_ASSERT(label, clk, rst_n, prop, msg)
`define RFA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- sv/rfa_pkg.sv -----
`timescale 1ns / 1ps
package rfa_pkg;
	localparam int IN_WIDTH_DEF = 16;
	localparam int ACC_WIDTH_DEF = 64;
	localparam int DEN_WIDTH = 15;
	localparam int OUT_DEN_WIDTH = 63;

	typedef struct packed {
		logic signed [15:0] frac_num;
		logic [14:0] frac_den;
		logic last;
	} in_word_t;

	typedef struct packed {
		logic signed [63:0] sum_num;
		logic [62:0] sum_den;
		logic signed [63:0] diff_num;
		logic [62:0] diff_den;
		logic signed [63:0] prod_num;
		logic [62:0] prod_den;
		logic signed [63:0] quot_num;
		logic signed [63:0] quot_den;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_GCD_START, ST_GCD_WAIT, ST_LCM_MUL,
		ST_SACC_WAIT, ST_SNEW_WAIT, ST_UPDATE, ST_MUL_WAIT, ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_GCD_DIV, OP_GCD_STEP, OP_LCM_DIV, OP_LCM_MUL,
		OP_SACC_DIV, OP_SNEW_DIV, OP_UPDATE, OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic mul_busy;
		logic gcd_done;
		logic at_start;
	} stat_t;
endpackage

// ----- sv/rfa_divider.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rfa_divider #(
	parameter int W = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic busy,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	localparam int CW = $clog2(W + 1);
	logic [CW-1:0] cnt_q;
	logic [W-1:0] quo_q, rem_q, dvs_q;
	logic [W:0] trial;
	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quotient = (dvs_q == '0) ? '0 : quo_q;
	assign remainder = rem_q;

	`RFA_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= CW'(W), "divider count out of range")
	`RFA_ASSERT(a_start_load, clk, arst_n, start |=> cnt_q == CW'(W), "divider start not taken")
	`RFA_ASSERT(a_count_down, clk, arst_n, (busy && !start) |=> cnt_q == $past(cnt_q) - 1'b1, "divider count skipped")
endmodule

// ----- sv/rfa_datapath.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rfa_datapath #(
	parameter int IN_WIDTH = rfa_pkg::IN_WIDTH_DEF,
	parameter int ACC_WIDTH = rfa_pkg::ACC_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  rfa_pkg::cmd_t cmd,
	input  rfa_pkg::in_word_t in_word,
	output rfa_pkg::stat_t stat,
	output rfa_pkg::out_word_t out_word
);
	localparam int A = ACC_WIDTH;
	localparam int MCNT = (A + 15) / 16;
	localparam int MCW = $clog2(MCNT + 1);
	logic [A-1:0] sum_q, diff_q, cden_q, pnum_q, pden_q, qnum_q, qden_q;
	logic [A-1:0] num_q, den_q, ga_q, gb_q, lcm_q, sacc_q;
	logic [A-1:0] ms_q, md_q, mr_q;
	logic [MCW-1:0] mcnt_q;
	logic at_start_q;
	logic dstart;
	logic [A-1:0] dn, dd, quo, rem;
	logic dbusy;
	logic [A-1:0] num_ext;
	logic [A-1:0] term;

	// x times a sign-extended 16-bit numerator, wrapped
	function automatic logic [A-1:0] mul_num(input logic [A-1:0] x, input logic [15:0] n);
		return x * A'(n) - (n[15] ? (x << 16) : '0);
	endfunction

	assign num_ext = A'($signed(in_word.frac_num[IN_WIDTH-1:0]));
	assign term = mul_num(quo, num_q[15:0]);

	rfa_divider #(.W(A)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .dividend(dn), .divisor(dd),
		.busy(dbusy), .quotient(quo), .remainder(rem)
	);

	always_comb begin
		dstart = 1'b0;
		dn = ga_q;
		dd = gb_q;
		case (cmd.op)
			rfa_pkg::OP_GCD_DIV: begin
				dstart = 1'b1;
			end
			rfa_pkg::OP_LCM_DIV: begin
				dstart = 1'b1;
				dn = cden_q;
				dd = ga_q;
			end
			rfa_pkg::OP_SACC_DIV: begin
				dstart = 1'b1;
				dn = lcm_q;
				dd = cden_q;
			end
			rfa_pkg::OP_SNEW_DIV: begin
				dstart = 1'b1;
				dn = lcm_q;
				dd = den_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			mcnt_q <= '0;
		end else begin
			if (cmd.op == rfa_pkg::OP_LOAD) begin
				at_start_q <= 1'b0;
			end else if (cmd.op == rfa_pkg::OP_CLEAR) begin
				at_start_q <= 1'b1;
			end
			if (cmd.op == rfa_pkg::OP_UPDATE) begin
				mcnt_q <= MCW'(MCNT);
			end else if (mcnt_q != '0) begin
				mcnt_q <= mcnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mcnt_q != '0) begin
			// scale sum and difference by sacc, 16 bits per cycle
			sum_q <= sum_q + ms_q * A'(mr_q[15:0]);
			diff_q <= diff_q + md_q * A'(mr_q[15:0]);
			ms_q <= ms_q << 16;
			md_q <= md_q << 16;
			mr_q <= mr_q >> 16;
		end else begin
			case (cmd.op)
				rfa_pkg::OP_LOAD: begin
					num_q <= num_ext;
					den_q <= A'(in_word.frac_den);
					ga_q <= cden_q;
					gb_q <= A'(in_word.frac_den);
					if (at_start_q) begin
						sum_q <= num_ext;
						diff_q <= num_ext;
						cden_q <= A'(in_word.frac_den);
						pnum_q <= num_ext;
						pden_q <= A'(in_word.frac_den);
						qnum_q <= num_ext;
						qden_q <= A'(in_word.frac_den);
					end
				end
				rfa_pkg::OP_GCD_STEP: begin
					ga_q <= gb_q;
					gb_q <= rem;
				end
				rfa_pkg::OP_LCM_MUL: begin
					lcm_q <= (cden_q == '0 || den_q == '0) ? '0 : quo * A'(den_q[14:0]);
				end
				rfa_pkg::OP_SNEW_DIV: begin
					sacc_q <= quo;
				end
				rfa_pkg::OP_UPDATE: begin
					ms_q <= sum_q;
					md_q <= diff_q;
					mr_q <= sacc_q;
					sum_q <= term;
					diff_q <= -term;
					cden_q <= lcm_q;
					pnum_q <= mul_num(pnum_q, num_q[15:0]);
					pden_q <= pden_q * A'(den_q[14:0]);
					qnum_q <= qnum_q * A'(den_q[14:0]);
					qden_q <= mul_num(qden_q, num_q[15:0]);
				end
				rfa_pkg::OP_CLEAR: begin
					sum_q <= '0;
					diff_q <= '0;
					cden_q <= A'(1);
					pnum_q <= A'(1);
					pden_q <= A'(1);
					qnum_q <= A'(1);
					qden_q <= A'(1);
				end
				default: ;
			endcase
		end
	end

	assign stat.div_busy = dbusy;
	assign stat.mul_busy = (mcnt_q != '0);
	assign stat.gcd_done = (gb_q == '0);
	assign stat.at_start = at_start_q;

	assign out_word.sum_num = 64'($signed(sum_q));
	assign out_word.sum_den = 63'(cden_q);
	assign out_word.diff_num = 64'($signed(diff_q));
	assign out_word.diff_den = 63'(cden_q);
	assign out_word.prod_num = 64'($signed(pnum_q));
	assign out_word.prod_den = 63'(pden_q);
	assign out_word.quot_num = 64'($signed(qnum_q));
	assign out_word.quot_den = 64'($signed(qden_q));

	`RFA_ASSERT(a_clear_start, clk, arst_n, cmd.op == rfa_pkg::OP_CLEAR |=> at_start_q, "clear did not restart")
	`RFA_ASSERT(a_load_start, clk, arst_n, cmd.op == rfa_pkg::OP_LOAD |=> !at_start_q, "load left start set")
	`RFA_ASSERT(a_step_idle, clk, arst_n, cmd.op == rfa_pkg::OP_GCD_STEP |-> !dbusy, "gcd step while dividing")
endmodule

// ----- sv/rfa_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rfa_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  rfa_pkg::stat_t stat,
	output rfa_pkg::cmd_t cmd
);
	rfa_pkg::state_t st_q, st_nx;
	logic last_q, first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rfa_pkg::ST_IDLE;
			last_q <= 1'b0;
			first_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (st_q == rfa_pkg::ST_IDLE && in_valid) begin
				last_q <= in_last;
				first_q <= stat.at_start;
			end
		end
	end

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			rfa_pkg::ST_IDLE: if (in_valid) st_nx = rfa_pkg::ST_LOAD;
			rfa_pkg::ST_LOAD: begin
				if (first_q) st_nx = last_q ? rfa_pkg::ST_OUT : rfa_pkg::ST_IDLE;
				else st_nx = rfa_pkg::ST_GCD_START;
			end
			rfa_pkg::ST_GCD_START: st_nx = stat.gcd_done ? rfa_pkg::ST_LCM_MUL : rfa_pkg::ST_GCD_WAIT;
			rfa_pkg::ST_GCD_WAIT: if (!stat.div_busy) st_nx = rfa_pkg::ST_GCD_START;
			rfa_pkg::ST_LCM_MUL: if (lcm_issued_q && !stat.div_busy) st_nx = rfa_pkg::ST_SACC_WAIT;
			rfa_pkg::ST_SACC_WAIT: if (!stat.div_busy) st_nx = rfa_pkg::ST_SNEW_WAIT;
			rfa_pkg::ST_SNEW_WAIT: if (!stat.div_busy) st_nx = rfa_pkg::ST_UPDATE;
			rfa_pkg::ST_UPDATE: if (!stat.div_busy) st_nx = rfa_pkg::ST_MUL_WAIT;
			rfa_pkg::ST_MUL_WAIT: begin
				if (!stat.mul_busy) st_nx = last_q ? rfa_pkg::ST_OUT : rfa_pkg::ST_IDLE;
			end
			rfa_pkg::ST_OUT: if (!out_stall) st_nx = rfa_pkg::ST_IDLE;
			default: st_nx = rfa_pkg::ST_IDLE;
		endcase
	end

	// LOAD uses captured at_start; first fraction captured via stat at accept
	logic lcm_issued_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lcm_issued_q <= 1'b0;
		else lcm_issued_q <= (st_q == rfa_pkg::ST_LCM_MUL) ? 1'b1 :
			(st_q == rfa_pkg::ST_IDLE ? 1'b0 : lcm_issued_q);
	end

	always_comb begin
		cmd.op = rfa_pkg::OP_NONE;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (st_q)
			rfa_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) cmd.op = rfa_pkg::OP_LOAD;
			end
			rfa_pkg::ST_GCD_START: if (!stat.gcd_done) cmd.op = rfa_pkg::OP_GCD_DIV;
			rfa_pkg::ST_GCD_WAIT: if (!stat.div_busy) cmd.op = rfa_pkg::OP_GCD_STEP;
			rfa_pkg::ST_LCM_MUL: begin
				if (!lcm_issued_q) cmd.op = rfa_pkg::OP_LCM_DIV;
				else if (!stat.div_busy) cmd.op = rfa_pkg::OP_LCM_MUL;
			end
			rfa_pkg::ST_SACC_WAIT: if (!stat.div_busy) cmd.op = rfa_pkg::OP_SACC_DIV;
			rfa_pkg::ST_SNEW_WAIT: if (!stat.div_busy) cmd.op = rfa_pkg::OP_SNEW_DIV;
			rfa_pkg::ST_UPDATE: if (!stat.div_busy) cmd.op = rfa_pkg::OP_UPDATE;
			rfa_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) cmd.op = rfa_pkg::OP_CLEAR;
			end
			default: ;
		endcase
	end

	`RFA_ASSERT(a_out_only, clk, arst_n, out_valid |-> st_q == rfa_pkg::ST_OUT, "output outside out state")
	`RFA_ASSERT(a_accept_idle, clk, arst_n, (in_valid && !in_stall) |-> st_q == rfa_pkg::ST_IDLE, "accept while busy")
	`RFA_ASSERT(a_clear_once, clk, arst_n, cmd.op == rfa_pkg::OP_CLEAR |=> st_q == rfa_pkg::ST_IDLE, "clear without return")
endmodule

// ----- sv/rational_fold_accumulator_top.sv -----
`timescale 1ns / 1ps
// Folds a list of fractions into unreduced sum, difference, product and quotient,
// emitting one word on the fraction marked last; one fraction at a time. The first
// fraction of a list is only loaded; a later one waits on Euclid steps and divisions
// in the single shared bit-serial divider and on a 16-bit slice multiply. A last
// fraction then presents the result word, held while out_stall is high.
module rational_fold_accumulator_top #(
	parameter int IN_WIDTH = rfa_pkg::IN_WIDTH_DEF,
	parameter int ACC_WIDTH = rfa_pkg::ACC_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  rfa_pkg::in_word_t in_word,
	output logic out_valid,
	input  logic out_stall,
	output rfa_pkg::out_word_t out_word
);
	rfa_pkg::cmd_t cmd;
	rfa_pkg::stat_t stat;

	rfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_last(in_word.last),
		.in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
		.stat(stat), .cmd(cmd)
	);

	rfa_datapath #(.IN_WIDTH(IN_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_word(in_word),
		.stat(stat), .out_word(out_word)
	);
endmodule
